// ===== sv/reciprocal_frequency_counter_defines.svh =====
// Assertion macros for the reciprocal frequency counter.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef RECIPROCAL_FREQUENCY_COUNTER_DEFINES_SVH
`define RECIPROCAL_FREQUENCY_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfc assertion failed");
// next-cycle implication
`define RFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfc assertion failed");
`else
`define RFC_ASSERT_NOW(label, ante, cons)
`define RFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/rfc_pkg.sv =====
// Shared types and constants for the reciprocal frequency counter.
// No dependencies.
package rfc_pkg;

	localparam int FRACTION_BITS = 8;

	localparam int TICK_W  = 32;
	localparam int CNT_W   = 8;
	localparam int TIME_W  = 16;
	localparam int OVF_W   = 8;
	localparam int KIND_W  = 2;
	localparam int FREQ_W  = 32;
	localparam int TOT_W   = 16;
	localparam int REF_W   = 24;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	// serial multiply / divide
	localparam int PROD_W   = TOT_W + REF_W;
	localparam int NUM_W    = PROD_W + FRACTION_BITS;
	localparam int NUM_HI_W = NUM_W - FREQ_W;
	localparam int MD_CNT_W = $clog2(FREQ_W);

	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_CLOCK = 2'd2;

	localparam logic [TICK_W-1:0] UPDATE_INTERVAL_RST = 32'd1000000;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST   = 32'd2000000;
	localparam logic [REF_W-1:0]  REFERENCE_CLOCK_RST = 24'd16000000;

	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREQ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DECIDE,
		ST_CALC,
		ST_DONE
	} rfc_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_CHECK,
		MD_DIV
	} rfc_md_phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rfc_md_sts_t;

endpackage

// ===== sv/rfc_if.sv =====
// Valid/ready channel interfaces for poll and result beats.
// Depends on rfc_pkg.
interface rfc_poll_if import rfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] elapsed_ticks;
	logic [CNT_W-1:0]  capture_count;
	logic [TIME_W-1:0] capture_time;
	logic [OVF_W-1:0]  capture_overflows;

	modport source (output valid, elapsed_ticks, capture_count, capture_time,
		capture_overflows, input ready);
	modport sink (input valid, elapsed_ticks, capture_count, capture_time,
		capture_overflows, output ready);
endinterface

interface rfc_result_if import rfc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [FREQ_W-1:0] frequency;

	modport source (output valid, result_kind, frequency, input ready);
	modport sink (input valid, result_kind, frequency, output ready);
endinterface

// ===== sv/rfc_mul_div.sv =====
// Bit-serial multiply then restoring divide: (count * refclk << FRACTION_BITS) / divisor.
// Saturates at all ones when the quotient does not fit. Depends on rfc_pkg.
module rfc_mul_div import rfc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TOT_W-1:0]  count,
	input  logic [REF_W-1:0]  refclk,
	input  logic [FREQ_W-1:0] divisor,
	output rfc_md_sts_t       sts,
	output logic [FREQ_W-1:0] quotient
);

	rfc_md_phase_t phase_q, phase_nx;
	logic [MD_CNT_W-1:0] cnt_q;
	logic done_q;

	logic [PROD_W-1:0] prod_q;
	logic [REF_W-1:0]  mcand_q;
	logic [FREQ_W-1:0] div_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] qsh_q;

	logic [REF_W:0]      mul_sum;
	logic [NUM_W-1:0]    num;
	logic [NUM_HI_W-1:0] num_hi;
	logic                sat;
	logic [FREQ_W:0]     trial;
	logic                take;
	logic                mul_last;
	logic                div_last;

	// LSB-first shift-add: multiplier sits in the low bits of prod_q
	assign mul_sum = {1'b0, prod_q[PROD_W-1:TOT_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : {(REF_W+1){1'b0}});
	assign num     = NUM_W'(prod_q) << FRACTION_BITS;
	assign num_hi  = num[NUM_W-1:FREQ_W];
	assign sat     = FREQ_W'(num_hi) >= div_q;
	assign trial   = {rem_q, qsh_q[FREQ_W-1]};
	assign take    = trial >= {1'b0, div_q};
	assign mul_last = cnt_q == MD_CNT_W'(TOT_W - 1);
	assign div_last = cnt_q == MD_CNT_W'(FREQ_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			done_q  <= (phase_q == MD_CHECK && sat) || (phase_q == MD_DIV && div_last);
			if (phase_q == MD_MUL || phase_q == MD_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			MD_IDLE:  if (start) phase_nx = MD_MUL;
			MD_MUL:   if (mul_last) phase_nx = MD_CHECK;
			MD_CHECK: phase_nx = sat ? MD_IDLE : MD_DIV;
			MD_DIV:   if (div_last) phase_nx = MD_IDLE;
			default:  phase_nx = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			MD_IDLE: begin
				if (start) begin
					prod_q  <= PROD_W'(count);
					mcand_q <= refclk;
					div_q   <= divisor;
				end
			end
			MD_MUL: prod_q <= {mul_sum, prod_q[TOT_W-1:1]};
			MD_CHECK: begin
				if (sat) begin
					qsh_q <= '1;
				end else begin
					rem_q <= FREQ_W'(num_hi);
					qsh_q <= num[FREQ_W-1:0];
				end
			end
			MD_DIV: begin
				rem_q <= take ? FREQ_W'(trial - {1'b0, div_q}) : trial[FREQ_W-1:0];
				qsh_q <= {qsh_q[FREQ_W-2:0], take};
			end
			default: ;
		endcase
	end

	assign sts.busy = phase_q != MD_IDLE;
	assign sts.done = done_q;
	assign quotient = qsh_q;

endmodule

// ===== sv/reciprocal_frequency_counter.sv =====
// Reciprocal frequency counter: one result beat per poll beat.
// Steps: the poll beat is registered, UPDATE adds it to the totals, DECIDE picks the kind,
// CALC runs the serial multiply, check and divide when a frequency is computed (the divide
// is skipped on saturation), and DONE moves the result into the output register.
// A new poll is taken only after DONE hands the last result to a free output register.
// arst_n clears all totals and loads the config registers with their defaults.
`include "reciprocal_frequency_counter_defines.svh"
module reciprocal_frequency_counter import rfc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	rfc_poll_if.sink             poll,
	rfc_result_if.source         result
);

	rfc_state_t state_q, state_nx;

	logic [TICK_W-1:0] upd_interval_q;
	logic [TICK_W-1:0] timeout_q;
	logic [REF_W-1:0]  refclk_q;

	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] time_total_q;
	logic [TOT_W-1:0]  cap_total_q;
	logic [TIME_W-1:0] last_time_q;
	logic [OVF_W-1:0]  last_ovf_q;

	// registered poll beat
	logic [TICK_W-1:0] in_elapsed_q;
	logic [CNT_W-1:0]  in_count_q;
	logic [TIME_W-1:0] in_time_q;
	logic [OVF_W-1:0]  in_ovf_q;

	logic [KIND_W-1:0] kind_q;
	logic [FREQ_W-1:0] freq_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [FREQ_W-1:0] out_freq_q;

	logic              poll_take;
	logic              has_cap;
	logic              measure;
	logic              timed_out;
	logic              md_start;
	logic              out_free;
	logic [TICK_W:0]   elapsed_sum;
	logic [OVF_W-1:0]  ovf_diff;
	logic [TICK_W-1:0] period;
	logic [TOT_W:0]    cap_sum;

	rfc_md_sts_t       md_sts;
	logic [FREQ_W-1:0] md_quot;

	assign poll_take   = poll.valid && poll.ready;
	assign has_cap     = in_count_q != '0;
	assign measure     = has_cap && (elapsed_q > upd_interval_q);
	assign timed_out   = !has_cap && (elapsed_q > timeout_q);
	assign md_start    = state_q == ST_DECIDE && measure && time_total_q != '0;
	assign out_free    = !out_valid_q || result.ready;

	assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, in_elapsed_q};
	assign ovf_diff    = in_ovf_q - last_ovf_q;
	assign period      = {{(TICK_W-OVF_W-TIME_W){1'b0}}, ovf_diff, {TIME_W{1'b0}}}
		+ TICK_W'(in_time_q) - TICK_W'(last_time_q);
	assign cap_sum     = {1'b0, cap_total_q} + (TOT_W+1)'(in_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_interval_q <= UPDATE_INTERVAL_RST;
			timeout_q      <= TIMEOUT_TICKS_RST;
			refclk_q       <= REFERENCE_CLOCK_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_UPDATE_INTERVAL: upd_interval_q <= cfg_data[TICK_W-1:0];
				REG_TIMEOUT_TICKS:   timeout_q      <= cfg_data[TICK_W-1:0];
				REG_REFERENCE_CLOCK: refclk_q       <= cfg_data[REF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			elapsed_q    <= '0;
			time_total_q <= '0;
			cap_total_q  <= '0;
			last_time_q  <= '0;
			last_ovf_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_UPDATE) begin
				elapsed_q <= elapsed_sum[TICK_W] ? '1 : elapsed_sum[TICK_W-1:0];
				if (has_cap) begin
					time_total_q <= time_total_q + period;
					cap_total_q  <= cap_sum[TOT_W] ? '1 : cap_sum[TOT_W-1:0];
					last_time_q  <= in_time_q;
					last_ovf_q   <= in_ovf_q;
				end
			end
			if (state_q == ST_DECIDE && (measure || timed_out)) begin
				elapsed_q    <= '0;
				time_total_q <= '0;
				cap_total_q  <= '0;
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_take) begin
			in_elapsed_q <= poll.elapsed_ticks;
			in_count_q   <= poll.capture_count;
			in_time_q    <= poll.capture_time;
			in_ovf_q     <= poll.capture_overflows;
		end
		if (state_q == ST_DECIDE) begin
			kind_q <= measure ? KIND_FREQ : (timed_out ? KIND_TIMEOUT : KIND_NONE);
			freq_q <= '0;
		end
		if (state_q == ST_CALC && md_sts.done)
			freq_q <= md_quot;
		if (state_q == ST_DONE && out_free) begin
			out_kind_q <= kind_q;
			out_freq_q <= freq_q;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (poll_take) state_nx = ST_UPDATE;
			ST_UPDATE: state_nx = ST_DECIDE;
			ST_DECIDE: state_nx = md_start ? ST_CALC : ST_DONE;
			ST_CALC:   if (md_sts.done) state_nx = ST_DONE;
			ST_DONE:   if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	assign poll.ready         = state_q == ST_IDLE;
	assign result.valid       = out_valid_q;
	assign result.result_kind = out_kind_q;
	assign result.frequency   = out_freq_q;

	rfc_mul_div u_mul_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (md_start),
		.count    (cap_total_q),
		.refclk   (refclk_q),
		.divisor  (time_total_q),
		.sts      (md_sts),
		.quotient (md_quot)
	);

	// divider only runs while the FSM waits on it
	`RFC_ASSERT_NOW(a_md_busy_in_calc, md_sts.busy || md_sts.done, state_q == ST_CALC)
	// only a measurement carries a nonzero frequency
	`RFC_ASSERT_NOW(a_zero_freq, result.valid && result.result_kind != KIND_FREQ,
		result.frequency == '0)
	// a measurement or timeout decision in DECIDE clears the elapsed, time and capture totals
	`RFC_ASSERT_NEXT(a_clear_after_result,
		state_q == ST_DECIDE && (measure || timed_out),
		elapsed_q == '0 && time_total_q == '0 && cap_total_q == '0)

endmodule
